// ----- sv/cfei_pkg.sv -----
// Package for the coalescing free extent insert block.
// Holds status codes, the sequencer state type and the extent record type; no dependencies.
package cfei_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OVERLAP = 2'd1;
  localparam logic [1:0] ST_BADSIZE = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_RDNEXT,
    S_CMPNEXT,
    S_SHRD,
    S_SHWR,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
  } extent_t;

endpackage

// ----- sv/cfei_mem.sv -----
// Extent table memory: one write port and one registered read port.
// Depends on cfei_pkg for the extent record type.
module cfei_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  cfei_pkg::extent_t wdata,
  input  logic [AW-1:0]     raddr,
  output cfei_pkg::extent_t rdata
);
  import cfei_pkg::*;

  extent_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/coalescing_free_extent_insert.sv -----
// Top level of the coalescing free extent insert block.
// Depends on cfei_pkg and cfei_mem.
// One request is taken while busy is low. The sequencer walks the extent table held in a
// single memory, one entry at a time, and then, where a slot must be opened or closed,
// shifts the entries up or down by one place. The result is shown for one cycle with done
// high, in the cycle in which busy falls, and must be taken then; the receiver cannot stall.
module coalescing_free_extent_insert #(
  parameter int MAX_EXTENTS = 64,
  parameter int ADDR_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] block_addr,
  input  logic signed [31:0] request_size,
  output logic        done,
  output logic [1:0]  status,
  output logic signed [31:0] bytes_total_out,
  output logic [6:0]  extent_count_out
);
  import cfei_pkg::*;

  localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW = $clog2(MAX_EXTENTS + 1);

  state_t state, state_next;

  logic [31:0]   addr, sz;
  logic [32:0]   blk_end;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [31:0]   total;
  logic [1:0]    st_reg;
  extent_t       cur;
  logic [CW-1:0] sh;      // shift cursor
  logic          sh_up;   // open a slot (true) or close one (false)
  logic [CW-1:0] sh_end;
  extent_t       wr_rec;
  logic [CW-1:0] wr_pos;
  logic          add_cnt, sub_cnt;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  extent_t           wdata, rdata;

  cfei_mem #(.DEPTH(MAX_EXTENTS), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Rounding of the request size.
  logic [31:0] raw, sz8, szr;
  logic [32:0] end_in;
  logic        bad_raw, bad_end;
  assign raw     = request_size;
  assign sz8     = (raw < 32'd8) ? 32'd8 : raw;
  assign szr     = (sz8 + 32'd3) & ~32'd3;
  assign end_in  = {1'b0, block_addr} + {1'b0, szr};
  assign bad_raw = (raw == 32'd0) || raw[31];
  assign bad_end = end_in > (33'd1 << ADDR_BITS);

  logic [32:0] cs, ce, ns1, ns2, ns_cur;
  assign cs  = {1'b0, rdata.start};
  assign ce  = cs + {1'b0, rdata.size};
  assign ns1 = {1'b0, rdata.size} + {1'b0, sz};
  assign ns2 = {1'b0, cur.size} + {1'b0, sz} + {1'b0, rdata.size};
  assign ns_cur = {1'b0, cur.size} + {1'b0, sz};

  logic full;
  assign full = (count == CW'(MAX_EXTENTS));
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      total <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == S_DONE) begin
        done <= 1'b1;
        if (st_reg == ST_OK) begin
          total <= total + sz;
          if (add_cnt) count <= count + 1'b1;
          if (sub_cnt) count <= count - 1'b1;
        end
      end
    end
  end

  assign status           = st_reg;
  assign bytes_total_out  = total;
  assign extent_count_out = 7'(count);

  // Datapath registers, updated alongside the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        addr <= block_addr;
        sz <= szr;
        blk_end <= end_in;
        idx <= '0;
        add_cnt <= 1'b0;
        sub_cnt <= 1'b0;
        st_reg <= bad_raw || bad_end ? ST_BADSIZE : ST_OK;
      end
      S_CMP: begin
        cur <= rdata;
        if (cs > blk_end) begin
          if (full) st_reg <= ST_FULL;
          else begin
            wr_rec <= '{start: addr, size: sz};
            wr_pos <= idx; sh <= count; sh_end <= idx; sh_up <= 1'b1;
            add_cnt <= 1'b1;
          end
        end else if (cs == blk_end) begin
          if (ns1[32]) st_reg <= ST_BADSIZE;
          else begin
            wr_rec <= '{start: addr, size: ns1[31:0]};
            wr_pos <= idx;
          end
        end else if ({1'b0, addr} < ce) begin
          st_reg <= ST_OVERLAP;
        end else if ({1'b0, addr} == ce) begin
          if (idx + 1'b1 == count) begin
            if (ns1[32]) st_reg <= ST_BADSIZE;
            else begin
              wr_rec <= '{start: rdata.start, size: ns1[31:0]};
              wr_pos <= idx;
            end
          end
        end
        idx <= idx + 1'b1;
      end
      S_CMPNEXT: begin
        // idx points at the following extent here.
        if (cs < blk_end) st_reg <= ST_OVERLAP;
        else if (cs == blk_end) begin
          if (ns2[32]) st_reg <= ST_BADSIZE;
          else begin
            wr_rec <= '{start: cur.start, size: ns2[31:0]};
            wr_pos <= idx - 1'b1;
            sh <= idx; sh_end <= count - 1'b1; sh_up <= 1'b0;
            sub_cnt <= 1'b1;
          end
        end else if (ns_cur[32]) st_reg <= ST_BADSIZE;
        else begin
          wr_rec <= '{start: cur.start, size: ns_cur[31:0]};
          wr_pos <= idx - 1'b1;
        end
      end
      S_SHWR: begin
        if (sh_up) sh <= sh - 1'b1;
        else sh <= sh + 1'b1;
      end
      default: ;
    endcase
    if (state == S_RD && idx == count && st_reg == ST_OK) begin
      if (full) st_reg <= ST_FULL;
      else begin
        wr_rec <= '{start: addr, size: sz};
        wr_pos <= count;
        add_cnt <= 1'b1;
      end
    end
  end

  // Memory port control.
  logic [CW-1:0] src;
  assign src = sh_up ? sh - 1'b1 : sh + 1'b1;

  always_comb begin
    we    = 1'b0;
    waddr = AW'(wr_pos);
    wdata = wr_rec;
    raddr = AW'(idx);
    if (state == S_SHRD) raddr = AW'(src);
    if (state == S_SHWR) begin
      we = 1'b1; waddr = AW'(sh); wdata = rdata;
    end
    if (state == S_WRITE) we = 1'b1;
  end

  logic cmp_done, cmp_adj;
  assign cmp_done = (cs >= blk_end) || ({1'b0, addr} < ce);
  assign cmp_adj  = ({1'b0, addr} == ce);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_RD;
      S_RD: begin
        if (st_reg != ST_OK) state_next = S_DONE;
        else if (idx == count) state_next = full ? S_DONE : S_WRITE;
        else state_next = S_CMP;
      end
      S_CMP: begin
        if (cs > blk_end) state_next = full ? S_DONE : (count == idx ? S_WRITE : S_SHRD);
        else if (cmp_done) state_next = (cs == blk_end && !ns1[32]) ? S_WRITE : S_DONE;
        else if (cmp_adj) begin
          if (idx + 1'b1 == count) state_next = ns1[32] ? S_DONE : S_WRITE;
          else state_next = S_RDNEXT;
        end else state_next = S_RD;
      end
      S_RDNEXT: state_next = S_CMPNEXT;
      S_CMPNEXT: begin
        if (cs < blk_end) state_next = S_DONE;
        else if (cs == blk_end) state_next = ns2[32] ? S_DONE : S_SHRD;
        else state_next = ns_cur[32] ? S_DONE : S_WRITE;
      end
      S_SHRD: state_next = (sh == sh_end) ? S_WRITE : S_SHWR;
      S_SHWR: state_next = S_SHRD;
      S_WRITE: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  a_busy_done: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");
  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_EXTENTS))
    else $error("extent count above table size");
  a_total_hold: assert property (@(posedge clk) disable iff (rst)
      (done && status != ST_OK) |-> $stable(total))
    else $error("total moved on a rejected request");

endmodule
